FILE: src/fp10c_pkg.sv
// ----------------------------------------------------------------------------
// fp10c_pkg
// Shared types and constants for the fp10 format converter.
// ----------------------------------------------------------------------------
package fp10c_pkg;

    typedef enum logic [1:0] {
        KIND_I2H = 2'd0,
        KIND_H2I = 2'd1,
        KIND_F2H = 2'd2,
        KIND_H2F = 2'd3
    } kind_t;

    localparam logic [15:0] FP10_NEG_SIGNS = 16'hfe00;
    localparam logic [15:0] FP10_INF_CODE  = 16'h01f0;
    localparam logic [15:0] FP10_NAN_CODE  = 16'h01f1;
    localparam logic [31:0] F32_POS_NAN    = 32'h7f800001;
    localparam logic [31:0] F32_INF_BITS   = 32'h7f800000;
    localparam logic [31:0] F32_SIGN       = 32'h80000000;
    localparam logic [31:0] F32_OVF_LIMIT  = 32'h477c0000;
    localparam logic [31:0] F32_ZERO_LIMIT = 32'h36000000;
    localparam logic [31:0] INT_INVALID    = 32'h80000000;

endpackage

FILE: src/fp10c_if.sv
// ----------------------------------------------------------------------------
// fp10c_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
interface fp10c_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] operand;

    modport source (output valid, kind, operand, input ready);
    modport sink   (input valid, kind, operand, output ready);
endinterface

interface fp10c_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

FILE: src/fp10c_convert.sv
// ----------------------------------------------------------------------------
// fp10c_convert
// Combinational datapath for all four conversions.
// ----------------------------------------------------------------------------
module fp10c_convert
    import fp10c_pkg::*;
(
    input  logic [1:0]  kind,
    input  logic [31:0] operand,
    output logic [31:0] result
);

    logic [31:0] i2h_r;
    logic [31:0] h2i_r;
    logic [31:0] f2h_r;
    logic [31:0] h2f_r;

    // int32 -> fp10
    logic [31:0] i_mag;
    logic [4:0]  i_e;
    logic [15:0] i_sg;
    logic [15:0] i_q;
    logic [31:0] i_keep;
    logic [31:0] i_rem;
    logic [31:0] i_half;
    logic        i_inc;
    logic [4:0]  i_sh;

    always_comb
    begin
        i_sg  = operand[31] ? FP10_NEG_SIGNS : 16'h0000;
        i_mag = operand[31] ? (32'd0 - operand) : operand;
        i_e   = 5'd0;
        for (int k = 0; k < 32; k++)
        begin
            if (i_mag[k])
                i_e = 5'(k);
        end
        i_sh   = i_e - 5'd4;
        i_keep = i_mag >> i_sh;
        i_half = 32'd1 << (i_sh - 5'd1);
        i_rem  = i_mag & ((i_half << 1) - 32'd1);
        i_inc  = (i_rem > i_half) || ((i_rem == i_half) && i_keep[0]);
        i_q    = 16'h0000;
        if (operand == 32'd0)
            i2h_r = 32'd0;
        else if (i_mag[31:16] != 16'd0)
            i2h_r = {16'd0, i_sg | FP10_INF_CODE};
        else if (i_e <= 5'd4)
            i2h_r = {16'd0, i_sg | {7'd0, i_e + 5'd15,
                     4'(i_mag[3:0] << (3'd4 - i_e[2:0]))}};
        else
        begin
            i_q = {7'd0, i_e + 5'd15, i_keep[3:0]} + {15'd0, i_inc};
            if (i_q >= FP10_INF_CODE)
                i_q = FP10_INF_CODE;
            i2h_r = {16'd0, i_sg | i_q};
        end
    end

    // fp10 -> int32
    logic [4:0]  h_ex;
    logic [31:0] h_fr;
    logic [31:0] h_v;

    always_comb
    begin
        h_ex = operand[8:4];
        h_fr = {27'd0, 1'b1, operand[3:0]};
        h_v  = (h_ex >= 5'd19) ? (h_fr << (h_ex - 5'd19)) : (h_fr >> (5'd19 - h_ex));
        if (h_ex == 5'h1f)
            h2i_r = INT_INVALID;
        else if (h_ex < 5'd15)
            h2i_r = 32'd0;
        else
            h2i_r = operand[9] ? (32'd0 - h_v) : h_v;
    end

    // binary32 -> fp10
    logic [15:0] f_sg;
    logic [31:0] f_mag;
    logic [7:0]  f_e;
    logic [23:0] f_m;
    logic [4:0]  f_sh;
    logic [23:0] f_keep;
    logic [23:0] f_half;
    logic [23:0] f_rem;
    logic        f_inc;
    logic [15:0] f_q;

    always_comb
    begin
        f_sg  = operand[31] ? FP10_NEG_SIGNS : 16'h0000;
        f_mag = {1'b0, operand[30:0]};
        f_e   = f_mag[30:23];
        f_m   = {1'b1, f_mag[22:0]};
        f_sh  = (f_e < 8'd113) ? 5'(8'd132 - f_e) : 5'd19;
        f_keep = f_m >> f_sh;
        f_half = 24'd1 << (f_sh - 5'd1);
        f_rem  = f_m & ((f_half << 1) - 24'd1);
        f_inc  = (f_rem > f_half) || ((f_rem == f_half) && f_keep[0]);
        if (f_e < 8'd113)
            f_q = 16'(f_keep) + {15'd0, f_inc};
        else
            f_q = {7'd0, 5'(f_e - 8'd112), f_m[22:19]} + {15'd0, f_inc};
        if (f_mag > F32_INF_BITS)
            f2h_r = {16'd0, f_sg | FP10_NAN_CODE};
        else if (f_mag >= F32_OVF_LIMIT)
            f2h_r = {16'd0, f_sg | FP10_INF_CODE};
        else if (f_mag <= F32_ZERO_LIMIT)
            f2h_r = {16'd0, f_sg};
        else
            f2h_r = {16'd0, f_sg | f_q};
    end

    // fp10 -> binary32
    logic [31:0] g_sg;
    logic [3:0]  g_fr;
    logic [7:0]  g_fe;

    always_comb
    begin
        g_sg = operand[9] ? F32_SIGN : 32'd0;
        g_fr = operand[3:0];
        g_fe = {3'd0, operand[8:4]} + 8'd112;
        if (operand[8:4] == 5'd0)
        begin
            // denormal: normalise by leading-one position
            priority if (g_fr[3]) begin g_fe = 8'd112; g_fr = {g_fr[2:0], 1'b0}; end
            else if (g_fr[2])     begin g_fe = 8'd111; g_fr = {g_fr[1:0], 2'b0}; end
            else if (g_fr[1])     begin g_fe = 8'd110; g_fr = {g_fr[0], 3'b0}; end
            else                  begin g_fe = 8'd109; g_fr = 4'd0; end
        end
        if (operand[8:4] == 5'h1f)
            h2f_r = (operand[3:0] != 4'd0) ? (g_sg | F32_POS_NAN) : (g_sg | F32_INF_BITS);
        else if (operand[8:0] == 9'd0)
            h2f_r = g_sg;
        else
            h2f_r = g_sg | {1'b0, g_fe, g_fr, 19'd0};
    end

    always_comb
    begin
        unique case (kind_t'(kind))
            KIND_I2H: result = i2h_r;
            KIND_H2I: result = h2i_r;
            KIND_F2H: result = f2h_r;
            KIND_H2F: result = h2f_r;
            default:  result = h2f_r;
        endcase
    end

endmodule

FILE: src/fp10_format_converter_core.sv
// ----------------------------------------------------------------------------
// fp10_format_converter_core
// fp10 minifloat conversion unit: int32 / binary32 to and from fp10.
// ----------------------------------------------------------------------------
// channel   dir   fields
// req       in    kind[1:0], operand[31:0]
// rsp       out   result[31:0]
//
// One request per cycle unless a stall on rsp fills both stages; input register, then result register.
// Conversion logic sits between the two registers in a single pass.
// Reset clears both valid flags; payloads are not reset.
// A stall on rsp holds the result register; it blocks requests only while both stages are occupied.
module fp10_format_converter_core
    import fp10c_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    fp10c_in_if.sink   req,
    fp10c_out_if.source rsp
);

    logic        in_vld_reg;
    logic [1:0]  in_kind_reg;
    logic [31:0] in_op_reg;
    logic        out_vld_reg;
    logic [31:0] out_res_reg;
    logic [31:0] conv_res;
    logic        adv;

    assign adv       = !out_vld_reg || rsp.ready;
    assign req.ready = !in_vld_reg || adv;

    fp10c_convert u_conv
    (
        .kind    (in_kind_reg),
        .operand (in_op_reg),
        .result  (conv_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
                in_vld_reg <= req.valid;
            if (adv)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_kind_reg <= req.kind;
            in_op_reg   <= req.operand;
        end
        if (adv && in_vld_reg)
            out_res_reg <= conv_res;
    end

    assign rsp.valid  = out_vld_reg;
    assign rsp.result = out_res_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !rsp.ready |=> out_vld_reg && $stable(out_res_reg))
        else $error("result changed under stall");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && out_vld_reg && !rsp.ready |-> !req.ready)
        else $error("request accepted with pipeline full");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && adv |=> out_vld_reg)
        else $error("result lost");

endmodule

FILE: sim/fp10_format_converter_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp10_format_converter_core_tb
// Drives conversion requests of all four kinds through the valid/ready
// channels with random gaps and stalls, predicts each result bit for bit
// and compares every response against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fp10_format_converter_core_tb;
    import fp10c_pkg::*;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] operand;
    } conv_req_t;

    localparam int CLK_HALF   = 4;
    localparam int RST_CYCLES = 12;
    localparam int N_RANDOM   = 800;
    localparam int MAX_CYCLES = 200000;
    localparam int LONG_HOLD  = 60;

    logic clk;
    logic rst_n;

    fp10c_in_if  req ();
    fp10c_out_if rsp ();

    fp10_format_converter_core i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    conv_req_t   pending_reqs[$];
    logic [31:0] expected_results[$];
    int          n_errors;
    int          n_checked;
    int          kind_count[4];
    int          cycle_count;
    bit          stim_done;
    bit          hold_rsp;
    bit          drain_wait;
    int          req_gap;
    int          rsp_gap;
    int          hold_count;

    always
    begin
        clk = 1'b1;
        #CLK_HALF;
        clk = 1'b0;
        #CLK_HALF;
    end

    // ---------------- prediction ----------------

    // round to nearest even: m holds all bits, sh bits are dropped
    function automatic logic [31:0] rne(logic [31:0] kept, logic [31:0] m, int sh);
        logic rbit;
        logic lbit;
        logic sticky;
        rbit   = m[sh-1];
        lbit   = m[sh];
        sticky = (sh > 1) ? ((m & ((32'd1 << (sh - 1)) - 1)) != 0) : 1'b0;
        return kept + ((rbit && (lbit || sticky)) ? 32'd1 : 32'd0);
    endfunction

    function automatic logic [31:0] pred_int_to_fp10(logic [31:0] n);
        logic [31:0] sg;
        logic [31:0] mag;
        logic [31:0] q;
        int          msb;
        if (n == 0)
            return 32'd0;
        sg  = n[31] ? 32'(FP10_NEG_SIGNS) : 32'd0;
        mag = n[31] ? -n : n;
        msb = 31;
        while (!mag[msb])
            msb--;
        if (msb > 15)
            return sg | 32'(FP10_INF_CODE);
        if (msb <= 4)
            return sg | ((msb + 15) << 4) | ((mag << (4 - msb)) & 32'hf);
        q = ((msb + 15) << 4) | ((mag >> (msb - 4)) & 32'hf);
        q = rne(q, mag, msb - 4);
        if (q >= 32'(FP10_INF_CODE))
            q = 32'(FP10_INF_CODE);
        return sg | q;
    endfunction

    function automatic logic [31:0] pred_fp10_to_int(logic [9:0] x);
        logic [4:0]  ex;
        logic [31:0] v;
        ex = x[8:4];
        if (ex == 5'h1f)
            return INT_INVALID;
        if (ex < 15)
            return 32'd0;
        v = {27'd0, 1'b1, x[3:0]};
        v = (ex >= 19) ? (v << (ex - 19)) : (v >> (19 - ex));
        return x[9] ? -v : v;
    endfunction

    function automatic logic [31:0] pred_float_to_fp10(logic [31:0] b);
        logic [31:0] sg;
        logic [31:0] mag;
        logic [31:0] m;
        int          ex;
        int          sh;
        sg  = b[31] ? 32'(FP10_NEG_SIGNS) : 32'd0;
        mag = {1'b0, b[30:0]};
        ex  = mag[30:23];
        m   = {9'd0, mag[22:0]};
        if (mag > F32_INF_BITS)
            return sg | 32'(FP10_NAN_CODE);
        if (mag >= F32_OVF_LIMIT)
            return sg | 32'(FP10_INF_CODE);
        if (mag <= F32_ZERO_LIMIT)
            return sg;
        if (ex < 113)
        begin
            sh = 132 - ex;
            m[23] = 1'b1;
            return sg | rne(m >> sh, m, sh);
        end
        return sg | rne(((ex - 112) << 4) | (m >> 19), m, 19);
    endfunction

    function automatic logic [31:0] pred_fp10_to_float(logic [9:0] x);
        logic [31:0] sg;
        logic [31:0] fr;
        int          fe;
        sg = x[9] ? F32_SIGN : 32'd0;
        fr = {28'd0, x[3:0]};
        if (x[8:4] == 5'h1f)
            return (fr != 0) ? (sg | F32_POS_NAN) : (sg | F32_INF_BITS);
        if (x[8:4] == 0)
        begin
            if (fr == 0)
                return sg;
            fe = 113;
            while (!fr[3])
            begin
                fr = fr << 1;
                fe--;
            end
            fr = (fr << 1) & 32'hf;
            fe--;
        end
        else
            fe = x[8:4] + 112;
        return sg | (32'(fe) << 23) | (fr << 19);
    endfunction

    function automatic logic [31:0] convert(conv_req_t r);
        case (r.kind)
            KIND_I2H: return pred_int_to_fp10(r.operand);
            KIND_H2I: return pred_fp10_to_int(r.operand[9:0]);
            KIND_F2H: return pred_float_to_fp10(r.operand);
            default:  return pred_fp10_to_float(r.operand[9:0]);
        endcase
    endfunction

    // ---------------- stimulus ----------------

    task automatic push_req(kind_t k, logic [31:0] op);
        conv_req_t r;
        r.kind    = k;
        r.operand = op;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [31:0] rand_operand(kind_t k);
        logic [31:0] v;
        logic [31:0] mag;
        v = $urandom;
        case (k)
            KIND_I2H:
                case ($urandom_range(0, 3))
                    0: v = $urandom_range(0, 70000);
                    1: v = -$urandom_range(0, 70000);
                    2: v = v >> $urandom_range(0, 31);
                    default: ;
                endcase
            KIND_F2H:
                if ($urandom_range(0, 3) != 0)
                begin
                    // exponent near the fp10 range so rounding paths are hit
                    mag = {1'b0, 8'($urandom_range(100, 145)), v[22:0]};
                    if ($urandom_range(0, 2) == 0)
                        mag[18:0] = {1'b1, 18'($urandom_range(0, 1) ? 0 : v[17:0])};
                    v = {v[31], mag[30:0]};
                end
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        kind_t k;
        rst_n = 1'b0;
        stim_done = 1'b0;
        drain_wait = 1'b0;
        // extremes and special cases
        push_req(KIND_I2H, 32'd0);
        push_req(KIND_I2H, 32'd31);
        push_req(KIND_I2H, 32'hffff_ffe1);
        push_req(KIND_I2H, 32'd65535);
        push_req(KIND_I2H, 32'd65536);
        push_req(KIND_I2H, 32'h8000_0000);
        push_req(KIND_I2H, 32'h7fff_ffff);
        push_req(KIND_I2H, 32'd35);
        push_req(KIND_H2I, 32'h0000_01f0);
        push_req(KIND_H2I, 32'hffff_fff1);
        push_req(KIND_H2I, 32'h0000_03ef);
        push_req(KIND_H2I, 32'h0000_0205);
        push_req(KIND_F2H, 32'h7fc0_0000);
        push_req(KIND_F2H, 32'hff80_0000);
        push_req(KIND_F2H, F32_OVF_LIMIT);
        push_req(KIND_F2H, 32'h477b_ffff);
        push_req(KIND_F2H, 32'hb600_0000);
        push_req(KIND_F2H, 32'h3600_0001);
        push_req(KIND_F2H, 32'h0000_0001);
        push_req(KIND_F2H, 32'h3f80_0000);
        push_req(KIND_H2F, 32'h0000_03f1);
        push_req(KIND_H2F, 32'h0000_01f0);
        push_req(KIND_H2F, 32'h0000_0200);
        push_req(KIND_H2F, 32'h0000_0001);
        push_req(KIND_H2F, 32'hffff_fc0f);
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            k = kind_t'($urandom_range(0, 3));
            push_req(k, rand_operand(k));
            if (i == N_RANDOM / 2)
            begin
                // let everything drain before carrying on
                wait (pending_reqs.size() == 0);
                drain_wait = 1'b1;
                wait (expected_results.size() == 0);
                drain_wait = 1'b0;
            end
        end
        wait (pending_reqs.size() == 0);
        stim_done = 1'b1;
    end

    // ---------------- driver ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.kind    <= KIND_I2H;
            req.operand <= '0;
            req_gap     <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_results.push_back(convert(pending_reqs.pop_front()));
                kind_count[req.kind]++;
            end
            if (req.valid && !req.ready)
                ;
            else if (req_gap > 0)
            begin
                req.valid <= 1'b0;
                req_gap   <= req_gap - 1;
            end
            else if (!drain_wait && pending_reqs.size() > ((req.valid && !req.ready) ? 1 : 0)
                     && !(req.valid && req.ready && pending_reqs.size() == 0))
            begin
                req.valid   <= 1'b1;
                req.kind    <= pending_reqs[0].kind;
                req.operand <= pending_reqs[0].operand;
                req_gap     <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            end
            else
                req.valid <= 1'b0;
        end
    end

    // ---------------- long hold-off ----------------

    // one long hold-off early on to back up the pipeline
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_rsp   <= 1'b0;
            hold_count <= 0;
        end
        else if (!hold_rsp && n_checked == 40)
        begin
            hold_rsp   <= 1'b1;
            hold_count <= LONG_HOLD;
        end
        else if (hold_count > 0)
            hold_count <= hold_count - 1;
    end

    // ---------------- monitor ----------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready   <= 1'b0;
            rsp_gap     <= 0;
            n_errors    <= 0;
            n_checked   <= 0;
            cycle_count <= 0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: actual %h", rsp.result);
                    n_errors <= n_errors + 1;
                end
                else if (rsp.result !== expected_results[0])
                begin
                    $error("result: expected %h actual %h", expected_results[0], rsp.result);
                    n_errors <= n_errors + 1;
                    void'(expected_results.pop_front());
                end
                else
                    void'(expected_results.pop_front());
                n_checked <= n_checked + 1;
            end
            if ((!hold_rsp && n_checked == 40) || hold_count > 0)
                rsp.ready <= 1'b0;
            else if (rsp_gap > 0)
            begin
                rsp_gap   <= rsp_gap - 1;
                rsp.ready <= 1'b0;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if (rsp.valid && rsp.ready && cycle_count[9])
                    rsp_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
            end
        end
    end

    // ---------------- end of run ----------------

    initial
    begin
        wait (rst_n);
        fork
            begin
                wait (stim_done && !req.valid && expected_results.size() == 0);
                repeat (10) @(posedge clk);
            end
            wait (cycle_count >= MAX_CYCLES);
        join_any
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("Testbench completed WITH ERRORS");
        end
        else
        begin
            $display("checked %0d results: int->fp10 %0d, fp10->int %0d,",
                     n_checked, kind_count[0], kind_count[1]);
            $display("  float->fp10 %0d, fp10->float %0d, with stalls and a full drain",
                     kind_count[2], kind_count[3]);
            if (n_errors == 0 && expected_results.size() == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
